### hdl/mmm_pkg.sv
// Package: widths, command/status structs and helpers for the Montgomery multiplier.
`default_nettype none
package mmm_pkg;

   localparam int MOD_WIDTH = 16;
   localparam int K_W       = $clog2(MOD_WIDTH + 1);
   localparam int CNT_W     = $clog2(2 * MOD_WIDTH);
   localparam int IN_BYTES  = (3 * MOD_WIDTH + 7) / 8;
   localparam int OUT_BYTES = (MOD_WIDTH + 7) / 8;

   typedef enum logic [1:0] {
      PH_A_IN  = 2'd0,
      PH_B_IN  = 2'd1,
      PH_MUL   = 2'd2,
      PH_OUT   = 2'd3
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      red_step;
      logic      dbl_step;
      logic      mp_load;
      logic      mp_step;
      logic      mp_fin;
      logic      out_load;
      logic      out_err;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic           bad_mod;
      logic [K_W-1:0] k_len;
   } stat_type;

   // k = bit length of (m - 1), at least 1
   function automatic logic [K_W-1:0] k_of(input logic [MOD_WIDTH-1:0] m);
      logic [MOD_WIDTH-1:0] mm1;
      logic [K_W-1:0]       k;
      mm1 = m - MOD_WIDTH'(1);
      k   = K_W'(1);
      for (int i = 1; i < MOD_WIDTH; i++) begin
         if (mm1[i]) k = K_W'(i + 1);
      end
      return k;
   endfunction

endpackage
`default_nettype wire

### hdl/mmm_datapath.sv
// Datapath: operand reduction, R^2 doubling, bit-serial Montgomery product, result word.
`default_nettype none
module mmm_datapath (
   input  wire                               clock,
   input  wire  mmm_pkg::cmd_type            cmd,
   input  wire  [mmm_pkg::MOD_WIDTH-1:0]     in_a,
   input  wire  [mmm_pkg::MOD_WIDTH-1:0]     in_b,
   input  wire  [mmm_pkg::MOD_WIDTH-1:0]     in_m,
   output mmm_pkg::stat_type                 stat,
   output logic [mmm_pkg::MOD_WIDTH-1:0]     product,
   output logic                              bad_modulus
);
   import mmm_pkg::*;

   localparam int W = MOD_WIDTH;

   logic [W-1:0]   sa_ff, sa_in, sb_ff, sb_in;   // operand bits, MSB first
   logic [W-1:0]   ra_ff, ra_in, rb_ff, rb_in;   // residues / Montgomery forms
   logic [W-1:0]   m_ff, m_in, r2_ff, r2_in;
   logic [K_W-1:0] k_ff, k_in;
   logic [W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [W:0]     acc_ff, acc_in;
   logic [W-1:0]   prod_ff, prod_in;
   logic           bad_ff, bad_in;

   logic [W:0]     ta, tb, td;
   logic [W+1:0]   t1, t2;
   logic [W:0]     fin;
   logic [W-1:0]   one_m;

   always_comb begin
      ta    = {ra_ff, sa_ff[W-1]};
      tb    = {rb_ff, sb_ff[W-1]};
      td    = {r2_ff, 1'b0};
      t1    = {1'b0, acc_ff} + (x_ff[0] ? {2'b00, y_ff} : '0);
      t2    = t1[0] ? t1 + {2'b00, m_ff} : t1;
      fin   = (acc_ff >= {1'b0, m_ff}) ? acc_ff - {1'b0, m_ff} : acc_ff;
      one_m = (m_ff == W'(1)) ? '0 : W'(1);

      sa_in = sa_ff; sb_in = sb_ff; ra_in = ra_ff; rb_in = rb_ff;
      m_in = m_ff; r2_in = r2_ff; k_in = k_ff; x_in = x_ff; y_in = y_ff;
      acc_in = acc_ff; prod_in = prod_ff; bad_in = bad_ff;

      if (cmd.load) begin
         sa_in = in_a; sb_in = in_b; ra_in = '0; rb_in = '0;
         m_in  = in_m; k_in  = k_of(in_m);
         r2_in = (in_m == W'(1)) ? '0 : W'(1);
      end
      if (cmd.red_step) begin
         ra_in = (ta >= {1'b0, m_ff}) ? W'(ta - {1'b0, m_ff}) : ta[W-1:0];
         rb_in = (tb >= {1'b0, m_ff}) ? W'(tb - {1'b0, m_ff}) : tb[W-1:0];
         sa_in = sa_ff << 1;
         sb_in = sb_ff << 1;
      end
      if (cmd.dbl_step)
         r2_in = (td >= {1'b0, m_ff}) ? W'(td - {1'b0, m_ff}) : td[W-1:0];
      if (cmd.mp_load) begin
         acc_in = '0;
         case (cmd.phase)
            PH_A_IN: begin x_in = ra_ff; y_in = r2_ff; end
            PH_B_IN: begin x_in = rb_ff; y_in = r2_ff; end
            PH_MUL:  begin x_in = ra_ff; y_in = rb_ff; end
            PH_OUT:  begin x_in = ra_ff; y_in = one_m; end
            default: begin x_in = ra_ff; y_in = r2_ff; end
         endcase
      end
      if (cmd.mp_step) begin
         acc_in = t2[W+1:1];
         x_in   = x_ff >> 1;
      end
      if (cmd.mp_fin) begin
         if (cmd.phase == PH_B_IN) rb_in = fin[W-1:0];
         else                      ra_in = fin[W-1:0];
      end
      if (cmd.out_load) begin
         prod_in = cmd.out_err ? '0 : ra_ff;
         bad_in  = cmd.out_err;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in; sb_ff <= sb_in; ra_ff <= ra_in; rb_ff <= rb_in;
      m_ff <= m_in; r2_ff <= r2_in; k_ff <= k_in; x_ff <= x_in; y_ff <= y_in;
      acc_ff <= acc_in; prod_ff <= prod_in; bad_ff <= bad_in;
   end

   // bad modulus flag above the k length
   assign stat         = {~in_m[0], k_ff};
   assign product      = prod_ff;
   assign bad_modulus  = bad_ff;

endmodule
`default_nettype wire

### hdl/mmm_ctrl.sv
// Controller: sequences reduction, doubling and the four Montgomery products.
`default_nettype none
module mmm_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  mmm_pkg::stat_type stat,
   output mmm_pkg::cmd_type      cmd
);
   import mmm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_REDUCE, S_DOUBLE, S_MPLOAD, S_MP, S_FIN, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   phase_type        phase_ff, phase_in;
   logic             err_ff, err_in;
   logic             vld_ff, vld_in;
   logic             acc_req, slot_free;
   logic [CNT_W-1:0] dbl_last, mp_last;

   assign acc_req    = req_tvalid && req_tready;
   assign slot_free  = !vld_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign dbl_last   = CNT_W'({stat.k_len, 1'b0} - 1'b1);
   assign mp_last    = CNT_W'(stat.k_len - 1'b1);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; phase_in = phase_ff;
      err_in = err_ff; vld_in = vld_ff;
      cmd = '0;
      cmd.phase   = phase_ff;
      cmd.out_err = err_ff;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: if (acc_req) begin
            cmd.load = 1'b1;
            err_in   = stat.bad_mod;
            cnt_in   = '0;
            state_in = stat.bad_mod ? S_DONE : S_REDUCE;
         end
         S_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MOD_WIDTH - 1)) begin
               cnt_in = '0; state_in = S_DOUBLE;
            end
         end
         S_DOUBLE: begin
            cmd.dbl_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == dbl_last) begin
               phase_in = PH_A_IN; state_in = S_MPLOAD;
            end
         end
         S_MPLOAD: begin
            cmd.mp_load = 1'b1;
            cnt_in = '0; state_in = S_MP;
         end
         S_MP: begin
            cmd.mp_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mp_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.mp_fin = 1'b1;
            if (phase_ff == PH_OUT) state_in = S_DONE;
            else begin
               phase_in = phase_type'(phase_ff + 2'd1);
               state_in = S_MPLOAD;
            end
         end
         S_DONE: if (slot_free) begin
            cmd.out_load = 1'b1;
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; phase_ff <= PH_A_IN;
         err_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; phase_ff <= phase_in;
         err_ff <= err_in; vld_ff <= vld_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.red_step, cmd.dbl_step, cmd.mp_load, cmd.mp_step,
                cmd.mp_fin, cmd.out_load}))
      else $error("overlapping datapath commands");
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      acc_req |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");
   a_mp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MP |-> cnt_ff < CNT_W'(stat.k_len))
      else $error("product step count overran k");
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!vld_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule
`default_nettype wire

### hdl/montgomery_modular_multiplier_top.sv
// Top level: Montgomery modular multiplier, controller plus datapath.
//
//  channel | dir | tdata (low bit up)                      | tuser
//  req_    | in  | operand_a, operand_b, modulus (16 each)  | -
//  rsp_    | out | product (16)                            | bad_modulus
//
//  Work from acceptance to rsp_tvalid runs through the bit-serial
//  reduction of the operands, 2k doublings for R^2 mod m (k = bit length
//  of (modulus-1)) and four k-step Montgomery products (each with a load
//  and a finish state) sharing one add/shift unit. A bad modulus skips
//  straight to the result.
//  The next word is taken from the cycle after the result register is loaded.
//  Reset: synchronous, active high; clears control only.
//  Stalls: a new word is taken while the previous result waits on rsp_;
//  work halts at the end only if the result register is still full.
`default_nettype none
module montgomery_modular_multiplier_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // operand_a, operand_b, modulus
   input  wire  [8*mmm_pkg::IN_BYTES-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // product
   output logic [8*mmm_pkg::OUT_BYTES-1:0]     rsp_tdata,
   // bad_modulus
   output logic                                rsp_tuser
);
   import mmm_pkg::*;

   cmd_type                cmd;
   stat_type               stat;
   logic [MOD_WIDTH-1:0]   product;

   mmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mmm_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .in_a        (req_tdata[MOD_WIDTH-1:0]),
      .in_b        (req_tdata[2*MOD_WIDTH-1:MOD_WIDTH]),
      .in_m        (req_tdata[3*MOD_WIDTH-1:2*MOD_WIDTH]),
      .stat        (stat),
      .product     (product),
      .bad_modulus (rsp_tuser)
   );

   // product word, zero padded to whole bytes
   assign rsp_tdata = (8*OUT_BYTES)'(product);

endmodule
`default_nettype wire
